>>> hw/rtl/ptm_pkg.sv
`default_nettype none

package ptm_pkg;

    // Pool geometry
    localparam int POOL_TABLES = 64;
    localparam int LEVELS      = 4;
    localparam int IDX_W       = 9;
    localparam int ENTRIES     = 1 << IDX_W;
    localparam int TBL_W       = $clog2(POOL_TABLES);
    localparam int ADDR_W      = TBL_W + IDX_W;
    localparam int POOL_WORDS  = POOL_TABLES * ENTRIES;
    localparam int NF_W        = $clog2(POOL_TABLES + 1);
    localparam int LVL_W       = (LEVELS > 2) ? $clog2(LEVELS) : 1;

    // Field widths
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int WI_W       = 15;
    localparam int USED_W     = 7;
    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W    = PA_W - PAGE_SHIFT;

    localparam logic [PA_W-1:0] ENTRY_FLAGS = PA_W'(3);

    // Request kinds
    localparam logic REQ_MAP  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_CHECK,
        ST_LINK,
        ST_ZERO,
        ST_LEAF,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              req_type;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [WI_W-1:0]   word_index;
    } req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PA_W-1:0]   data;
    } pool_wr_t;

    typedef struct packed {
        logic              status;
        logic [PA_W-1:0]   read_data;
        logic [USED_W-1:0] tables_used;
    } result_t;

    // Table index at a given level: 9 bits of the virtual address from bit 12+9*level
    function automatic logic [IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
        logic [VA_W-1:0] s;
        s = va >> (PAGE_SHIFT + IDX_W * int'(lvl));
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ptm_pool_mem.sv
`default_nettype none

module ptm_pool_mem (
    input  wire logic                     aclk,
    input  wire ptm_pkg::pool_wr_t        wr,
    input  wire logic                     rd_en,
    input  wire logic [ptm_pkg::ADDR_W-1:0] rd_addr,
    output logic [ptm_pkg::PA_W-1:0]      rd_data
);
    import ptm_pkg::*;

    logic [PA_W-1:0] mem [POOL_WORDS];
    logic [PA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ptm_walk_ctrl.sv
`default_nettype none

module ptm_walk_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  wire ptm_pkg::req_t              in_req,
    output logic                            in_ready,
    input  wire logic [ptm_pkg::PA_W-1:0]   pool_base,
    output logic                            rd_en,
    output logic [ptm_pkg::ADDR_W-1:0]      rd_addr,
    input  wire logic [ptm_pkg::PA_W-1:0]   rd_data,
    output ptm_pkg::pool_wr_t               wr,
    output logic                            res_valid,
    output ptm_pkg::result_t                res,
    input  wire logic                       res_ready
);
    import ptm_pkg::*;

    ctrl_state_t       state_reg,  state_next;
    req_t              req_reg,    req_next;
    logic [TBL_W-1:0]  t_reg,      t_next;
    logic [LVL_W-1:0]  lvl_reg,    lvl_next;
    logic [NF_W-1:0]   nf_reg,     nf_next;
    logic [ADDR_W-1:0] clr_reg,    clr_next;
    logic              status_reg, status_next;
    logic [PA_W-1:0]   data_reg,   data_next;
    logic [POOL_TABLES-1:0] dirty_reg, dirty_next;

    logic [FRAME_W-1:0] link_off;
    logic               link_ok;
    logic               present;
    logic               pool_full;
    logic               wi_in_range;
    logic [FRAME_W-1:0] new_frame;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            nf_reg    <= NF_W'(1);
            dirty_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nf_reg    <= nf_next;
            dirty_reg <= dirty_next;
        end
    end

    // Request and walk payload
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        t_reg      <= t_next;
        lvl_reg    <= lvl_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    // Link decode and allocation arithmetic
    assign present     = rd_data[0];
    assign link_off    = rd_data[PA_W-1:PAGE_SHIFT] - pool_base[PA_W-1:PAGE_SHIFT];
    assign link_ok     = (link_off >> TBL_W) == '0;
    assign pool_full   = ((NF_W+1)'(nf_reg) + (NF_W+1)'(lvl_reg)) > (NF_W+1)'(POOL_TABLES);
    assign wi_in_range = 32'(req_reg.word_index) < 32'(POOL_WORDS);
    assign new_frame   = pool_base[PA_W-1:PAGE_SHIFT] + FRAME_W'(nf_reg);

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        t_next      = t_reg;
        lvl_next    = lvl_reg;
        nf_next     = nf_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        data_next   = data_reg;
        dirty_next  = dirty_reg;
        in_ready    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {t_reg, lvl_index(req_reg.virt_addr, lvl_reg)};
        wr          = '0;
        res_valid   = 1'b0;

        unique case (state_reg)
            // After reset, zero the pool one word a cycle
            ST_CLEAR: begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                wr.data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(POOL_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next    = in_req;
                    t_next      = '0;
                    lvl_next    = LVL_W'(LEVELS - 1);
                    status_next = STATUS_OK;
                    data_next   = '0;
                    state_next  = ST_ISSUE;
                end
            end
            // Present the read address for a pool read or the current walk level
            ST_ISSUE: begin
                rd_en = 1'b1;
                if (req_reg.req_type == REQ_READ) begin
                    rd_addr = ADDR_W'(req_reg.word_index);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (req_reg.req_type == REQ_READ) begin
                    data_next  = wi_in_range ? rd_data : '0;
                    state_next = ST_DONE;
                end else if (!present) begin
                    // Missing level: allocate only if the whole chain fits
                    if (pool_full) begin
                        status_next = STATUS_FULL;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_LINK;
                    end
                end else if (!link_ok) begin
                    status_next = STATUS_FULL;
                    state_next  = ST_DONE;
                end else begin
                    t_next = link_off[TBL_W-1:0];
                    if (lvl_reg == LVL_W'(1)) begin
                        state_next = ST_LEAF;
                    end else begin
                        lvl_next   = lvl_reg - LVL_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            // Link a fresh table and descend into it
            ST_LINK: begin
                if (dirty_reg[nf_reg[TBL_W-1:0]]) begin
                    // The fresh table was written before allocation: zero it first
                    clr_next   = {nf_reg[TBL_W-1:0], IDX_W'(0)};
                    state_next = ST_ZERO;
                end else begin
                    wr.en   = 1'b1;
                    wr.addr = {t_reg, lvl_index(req_reg.virt_addr, lvl_reg)};
                    wr.data = {new_frame, PAGE_SHIFT'(0)} | ENTRY_FLAGS;
                    if (NF_W'(t_reg) >= nf_reg) begin
                        dirty_next[t_reg] = 1'b1;
                    end
                    t_next  = nf_reg[TBL_W-1:0];
                    nf_next = nf_reg + NF_W'(1);
                    if (lvl_reg == LVL_W'(1)) begin
                        state_next = ST_LEAF;
                    end else begin
                        lvl_next = lvl_reg - LVL_W'(1);
                    end
                end
            end
            // Clear the table about to be allocated, one word a cycle
            ST_ZERO: begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                wr.data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg[IDX_W-1:0] == '1) begin
                    dirty_next[nf_reg[TBL_W-1:0]] = 1'b0;
                    state_next = ST_LINK;
                end
            end
            ST_LEAF: begin
                wr.en      = 1'b1;
                wr.addr    = {t_reg, lvl_index(req_reg.virt_addr, LVL_W'(0))};
                wr.data    = req_reg.phys_addr | ENTRY_FLAGS;
                if (NF_W'(t_reg) >= nf_reg) begin
                    dirty_next[t_reg] = 1'b1;
                end
                state_next = ST_DONE;
            end
            // Hold the result until the output slot frees
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.read_data   = data_reg;
    assign res.tables_used = USED_W'(nf_reg);

endmodule

`default_nettype wire

>>> hw/rtl/page_table_mapper_unit.sv
// Page table mapper: builds a four-level page table in a pool of 64 tables of
// 512 52-bit words held in one on-chip memory (table k sits at pool_base plus
// k*4096, table 0 is the root). A map transfer walks the levels from the root,
// allocating and linking fresh tables where an entry is not present, then
// writes phys_addr|0x3 into the leaf; if the pool cannot hold the new tables,
// or a link points outside the pool, nothing changes and status is 1. A read
// transfer (tuser high) returns one pool word. A request takes a memory read
// and a check for each level walked, plus a write for each linked level and
// the leaf; the pool memory has a single read port, and its read is registered.
// A table that was written through a stale link before it was allocated
// (possible after pool_base moves) is zeroed when it is allocated.
// One request is in the block at a time; the next is accepted while the last
// result waits on m_tready. After reset the block zeroes the pool, one word a
// cycle, holding s_tready low until the whole pool is clear; configuration
// writes are taken throughout. Write pool_base only while the block is idle.
`default_nettype none

module page_table_mapper_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration: pool_base
    input  wire logic         cfg_we,
    input  wire logic [51:0]  cfg_wdata,
    // Request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,  // virt_addr[47:0], phys_addr[99:48], word_index[114:100]
    input  wire logic         s_tuser,  // req_type
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata   // status[0], read_data[52:1], tables_used[59:53]
);
    import ptm_pkg::*;

    logic [PA_W-1:0] pool_base_reg;
    logic            m_tvalid_reg;
    result_t         out_reg;

    req_t            in_req;
    logic            rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PA_W-1:0] rd_data;
    pool_wr_t        wr;
    logic            res_valid;
    result_t         res;
    logic            res_ready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
        end else if (cfg_we) begin
            pool_base_reg <= cfg_wdata;
        end
    end

    // Unpack the request
    assign in_req.req_type   = s_tuser;
    assign in_req.virt_addr  = s_tdata[47:0];
    assign in_req.phys_addr  = s_tdata[99:48];
    assign in_req.word_index = s_tdata[114:100];

    ptm_pool_mem u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptm_walk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_req    (in_req),
        .in_ready  (s_tready),
        .pool_base (pool_base_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr        (wr),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg.tables_used, out_reg.read_data, out_reg.status};

endmodule

`default_nettype wire

>>> hw/rtl/ptm_checker.sv
`default_nettype none

module ptm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset starts the clearing pass with nothing pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block ready or busy straight after reset");

    // One request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    // Table count stays within the pool, root included
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[59:53] != 7'd0 && m_tdata[59:53] <= 7'd64)
        else $error("tables in use out of range");

    // Only a successful read carries data
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[52:1] != 52'd0 |-> !m_tdata[0])
        else $error("refused request returned data");

endmodule

bind page_table_mapper_unit ptm_checker u_ptm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
